FILE: rtl/dmc_pkg.sv
// Shared types, codes and default sizes of the direct-mapped MSI cache.
package dmc_pkg;

   // default sizes
   localparam int DEF_LINES           = 8;
   localparam int DEF_BASE_LINE_WORDS = 4;
   localparam int DEF_SCALE           = 1;
   localparam int DEF_ADDR_BITS       = 16;

   // fixed field widths
   localparam int SNOOP_BITS = 14;
   localparam int BUSA_BITS  = 16;

   // request types
   localparam logic [2:0] REQ_READ        = 3'd0;
   localparam logic [2:0] REQ_WRITE       = 3'd1;
   localparam logic [2:0] REQ_REFILL      = 3'd2;
   localparam logic [2:0] REQ_SNOOP_INV   = 3'd3;
   localparam logic [2:0] REQ_SNOOP_QUERY = 3'd4;
   localparam logic [2:0] REQ_SNOOP_WB    = 3'd5;

   // response status codes
   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_RETRY = 2'd1;
   localparam logic [1:0] STAT_MISS  = 2'd2;
   localparam logic [1:0] STAT_SNOOP = 2'd3;

   // bus commands
   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_FETCH = 2'd2;
   localparam logic [1:0] CMD_INV   = 2'd3;

   // line states
   localparam logic [1:0] LS_INVALID  = 2'd0;
   localparam logic [1:0] LS_CLEAN    = 2'd1;
   localparam logic [1:0] LS_MODIFIED = 2'd2;

   // one response word
   typedef struct packed {
      logic [1:0]           status_code;
      logic [31:0]          read_data;
      logic                 hit;
      logic                 modified_answer;
      logic [1:0]           bus_cmd;
      logic [BUSA_BITS-1:0] bus_address;
      logic [31:0]          bus_data;
      logic                 last;
   } rsp_type;

endpackage

FILE: rtl/direct_mapped_msi_cache_unit.sv
// Direct-mapped write-back MSI cache: processor, refill and snoop requests.
//
// Requests arrive on req_* (valid/stall); every request, processor access,
// refill word or snoop, goes in on the same channel. Responses leave on rsp_*
// (valid/stall); rsp_last marks the final response of a request.
// The block works on one request at a time and holds req_stall high from
// acceptance until it is idle again. States S_DIV1, S_DIV2 and S_DIV3 split
// the address into block, line index and offset (constant reciprocal
// multiplies); S_DIV3 also issues the tag/state memory read, used in S_META.
// A request with a single response has it loaded in S_RESP. Each line word
// is read from the single read port of the data memory in an issue state and
// sent in an out state: a read hit or a finished read refill loads its SCALE
// words, a snoop writeback its LW words, a dirty victim adds its LW words
// ahead of the fetch response, and a finished write refill adds S_FILLW to
// store the pending word. Requests with no response go back to S_IDLE from
// S_META, and the next request is taken in S_IDLE.
// Reset clears all line valid bits and the pending miss at once; no clearing
// pass is needed. While rsp_stall is high the held response stays put and
// the block waits, with req_stall high, until it can place the next one.
module direct_mapped_msi_cache_unit #(
   parameter int LINES           = dmc_pkg::DEF_LINES,
   parameter int BASE_LINE_WORDS = dmc_pkg::DEF_BASE_LINE_WORDS,
   parameter int SCALE           = dmc_pkg::DEF_SCALE,
   parameter int ADDR_BITS       = dmc_pkg::DEF_ADDR_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [2:0]                      req_type,
   input  logic [ADDR_BITS-1:0]            req_word_address,
   input  logic [31:0]                     req_write_data,
   input  logic [31:0]                     req_refill_word,
   input  logic [dmc_pkg::SNOOP_BITS-1:0]  req_snoop_block,
   input  logic                            req_bus_busy,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status_code,
   output logic [31:0]                     rsp_read_data,
   output logic                            rsp_hit,
   output logic                            rsp_modified_answer,
   output logic [1:0]                      rsp_bus_cmd,
   output logic [dmc_pkg::BUSA_BITS-1:0]   rsp_bus_address,
   output logic [31:0]                     rsp_bus_data,
   output logic                            rsp_last
);

   localparam int AB    = ADDR_BITS;
   localparam int SB    = dmc_pkg::SNOOP_BITS;
   localparam int BA    = dmc_pkg::BUSA_BITS;
   localparam int LW    = BASE_LINE_WORDS * SCALE;
   localparam int LWL   = $clog2(LW);
   localparam int OFFW  = (LW > 1) ? $clog2(LW) : 1;
   localparam int CNTW  = $clog2(LW + 1);
   localparam int IDXW  = $clog2(LINES);
   localparam int DEPTH = LINES * LW;
   localparam int DAW   = $clog2(DEPTH);
   localparam int MW    = 2 + AB;
   localparam int CW    = (AB > SB) ? AB : SB;
   localparam int PW    = 2 * AB + 2;
   localparam int SPW   = 2 * SB + 2;

   // reciprocals for exact division by constants
   localparam int K1 = AB + LWL;
   localparam int K2 = AB + IDXW;
   localparam int K3 = SB + IDXW;
   localparam logic [63:0] M1 = ((64'd1 << K1) + 64'(LW) - 64'd1) / 64'(LW);
   localparam logic [63:0] M2 = ((64'd1 << K2) + 64'(LINES) - 64'd1) / 64'(LINES);
   localparam logic [63:0] M3 = ((64'd1 << K3) + 64'(LINES) - 64'd1) / 64'(LINES);

   // sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DIV1     = 4'd1;
   localparam logic [3:0] S_DIV2     = 4'd2;
   localparam logic [3:0] S_DIV3     = 4'd3;
   localparam logic [3:0] S_META     = 4'd4;
   localparam logic [3:0] S_RESP     = 4'd5;
   localparam logic [3:0] S_WB_ISSUE = 4'd6;
   localparam logic [3:0] S_WB_OUT   = 4'd7;
   localparam logic [3:0] S_RD_ISSUE = 4'd8;
   localparam logic [3:0] S_RD_OUT   = 4'd9;
   localparam logic [3:0] S_FILLW    = 4'd10;

   logic [3:0]            state_ff, state_in;
   logic [2:0]            type_ff, type_in;
   logic [AB-1:0]         addr_ff, addr_in;
   logic [31:0]           wdata_ff, wdata_in;
   logic [31:0]           rword_ff, rword_in;
   logic [SB-1:0]         sblock_ff, sblock_in;
   logic                  busy_ff, busy_in;
   logic [AB-1:0]         block_ff, block_in;
   logic [SB-1:0]         sq_ff, sq_in;
   logic [AB-1:0]         iq_ff, iq_in;
   logic [OFFW-1:0]       off_ff, off_in;
   logic [IDXW-1:0]       sidx_ff, sidx_in;
   logic [IDXW-1:0]       idx_ff, idx_in;
   logic [IDXW-1:0]       midx_ff, midx_in;
   logic [LINES-1:0]      valid_ff, valid_in;
   logic                  pend_ff, pend_in;
   logic                  pwrite_ff, pwrite_in;
   logic [AB-1:0]         pblock_ff, pblock_in;
   logic [IDXW-1:0]       pidx_ff, pidx_in;
   logic [OFFW-1:0]       poff_ff, poff_in;
   logic [31:0]           pdata_ff, pdata_in;
   logic [CNTW-1:0]       rc_ff, rc_in;
   logic [CNTW-1:0]       cnt_ff, cnt_in;
   logic [IDXW-1:0]       row_ff, row_in;
   logic [OFFW-1:0]       roff_ff, roff_in;
   logic                  rdhit_ff, rdhit_in;
   logic [AB-1:0]         wtag_ff, wtag_in;
   logic [1:0]            wst_ff, wst_in;
   logic                  wbsnoop_ff, wbsnoop_in;
   dmc_pkg::rsp_type      res_ff, res_in;
   dmc_pkg::rsp_type      rsp_ff, rsp_in;
   logic                  rspv_ff, rspv_in;

   logic [PW-1:0]         prod1, prod2;
   logic [SPW-1:0]        prod3;
   logic [IDXW-1:0]       idx_calc;
   logic                  rsp_free;
   logic                  rsp_load;

   logic                  mwe;
   logic [IDXW-1:0]       mwaddr;
   logic [MW-1:0]         mwdata;
   logic [IDXW-1:0]       mraddr;
   logic [MW-1:0]         mrdata;
   logic                  dwe;
   logic [DAW-1:0]        dwaddr;
   logic [31:0]           dwdata;
   logic [DAW-1:0]        draddr;
   logic [31:0]           drdata;

   logic [AB-1:0]         tag_rd;
   logic [1:0]            st_rd;
   logic                  hit, shit, smatch;
   logic [OFFW:0]         wrap_sum;
   logic [OFFW-1:0]       rd_woff;

   // state memories
   dmc_ram #(.WIDTH(MW), .DEPTH(LINES)) u_meta (
      .clock   (clock),
      .wr_en   (mwe),
      .wr_addr (mwaddr),
      .wr_data (mwdata),
      .rd_addr (mraddr),
      .rd_data (mrdata)
   );

   dmc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_data (
      .clock   (clock),
      .wr_en   (dwe),
      .wr_addr (dwaddr),
      .wr_data (dwdata),
      .rd_addr (draddr),
      .rd_data (drdata)
   );

   // address split arithmetic
   assign prod1    = PW'(addr_ff) * PW'(M1);
   assign prod2    = PW'(block_ff) * PW'(M2);
   assign prod3    = SPW'(sblock_ff) * SPW'(M3);
   assign idx_calc = IDXW'(block_ff - AB'(iq_ff * AB'(LINES)));

   // line lookup
   assign tag_rd = mrdata[AB-1:0];
   assign st_rd  = valid_ff[midx_ff] ? mrdata[MW-1:AB] : dmc_pkg::LS_INVALID;
   assign hit    = (CW'(tag_rd) == CW'(block_ff)) && (st_rd != dmc_pkg::LS_INVALID);
   assign smatch = (CW'(tag_rd) == CW'(sblock_ff));
   assign shit   = smatch && (st_rd != dmc_pkg::LS_INVALID);
   assign mraddr = (type_ff == dmc_pkg::REQ_SNOOP_INV || type_ff == dmc_pkg::REQ_SNOOP_QUERY ||
                    type_ff == dmc_pkg::REQ_SNOOP_WB) ? sidx_ff : idx_calc;

   // read word offset wraps within the line
   assign wrap_sum = (OFFW + 1)'(roff_ff) + (OFFW + 1)'(cnt_ff);
   assign rd_woff  = (wrap_sum >= (OFFW + 1)'(LW)) ? OFFW'(wrap_sum - (OFFW + 1)'(LW))
                                                    : OFFW'(wrap_sum);
   assign draddr   = (state_ff == S_WB_ISSUE || state_ff == S_WB_OUT)
                   ? DAW'(DAW'(row_ff) * DAW'(LW) + DAW'(cnt_ff[OFFW-1:0]))
                   : DAW'(DAW'(row_ff) * DAW'(LW) + DAW'(rd_woff));

   assign rsp_free = !rspv_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      type_in    = type_ff;
      addr_in    = addr_ff;
      wdata_in   = wdata_ff;
      rword_in   = rword_ff;
      sblock_in  = sblock_ff;
      busy_in    = busy_ff;
      block_in   = block_ff;
      sq_in      = sq_ff;
      iq_in      = iq_ff;
      off_in     = off_ff;
      sidx_in    = sidx_ff;
      idx_in     = idx_ff;
      midx_in    = midx_ff;
      valid_in   = valid_ff;
      pend_in    = pend_ff;
      pwrite_in  = pwrite_ff;
      pblock_in  = pblock_ff;
      pidx_in    = pidx_ff;
      poff_in    = poff_ff;
      pdata_in   = pdata_ff;
      rc_in      = rc_ff;
      cnt_in     = cnt_ff;
      row_in     = row_ff;
      roff_in    = roff_ff;
      rdhit_in   = rdhit_ff;
      wtag_in    = wtag_ff;
      wst_in     = wst_ff;
      wbsnoop_in = wbsnoop_ff;
      res_in     = res_ff;
      rsp_in     = rsp_ff;
      rsp_load   = 1'b0;
      mwe        = 1'b0;
      mwaddr     = midx_ff;
      mwdata     = {dmc_pkg::LS_CLEAN, tag_rd};
      dwe        = 1'b0;
      dwaddr     = DAW'(DAW'(idx_ff) * DAW'(LW) + DAW'(off_ff));
      dwdata     = wdata_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               type_in   = req_type;
               addr_in   = req_word_address;
               wdata_in  = req_write_data;
               rword_in  = req_refill_word;
               sblock_in = req_snoop_block;
               busy_in   = req_bus_busy;
               state_in  = S_DIV1;
            end
         end
         S_DIV1: begin
            block_in = AB'(prod1 >> K1);
            sq_in    = SB'(prod3 >> K3);
            state_in = S_DIV2;
         end
         S_DIV2: begin
            off_in   = OFFW'(addr_ff - AB'(block_ff * AB'(LW)));
            iq_in    = AB'(prod2 >> K2);
            sidx_in  = IDXW'(sblock_ff - SB'(sq_ff * SB'(LINES)));
            state_in = S_DIV3;
         end
         S_DIV3: begin
            idx_in   = idx_calc;
            midx_in  = mraddr;
            state_in = S_META;
         end
         S_META: begin
            res_in      = '0;
            res_in.last = 1'b1;
            state_in    = S_RESP;
            case (type_ff)
               dmc_pkg::REQ_READ, dmc_pkg::REQ_WRITE: begin
                  if (pend_ff) begin
                     res_in.status_code = dmc_pkg::STAT_RETRY;
                  end else if (type_ff == dmc_pkg::REQ_READ && hit) begin
                     row_in   = idx_ff;
                     roff_in  = off_ff;
                     rdhit_in = 1'b1;
                     cnt_in   = '0;
                     state_in = S_RD_ISSUE;
                  end else if (busy_ff) begin
                     res_in.status_code = dmc_pkg::STAT_RETRY;
                     res_in.hit         = hit;
                  end else if (hit) begin
                     // write hit: store word, mark modified, broadcast
                     dwe    = 1'b1;
                     mwe    = 1'b1;
                     mwdata = {dmc_pkg::LS_MODIFIED, tag_rd};
                     res_in.status_code = dmc_pkg::STAT_DONE;
                     res_in.hit         = 1'b1;
                     res_in.bus_cmd     = dmc_pkg::CMD_INV;
                     res_in.bus_address = BA'(block_ff);
                  end else begin
                     // miss: drop line, record pending fetch
                     valid_in[idx_ff] = 1'b0;
                     pend_in   = 1'b1;
                     pwrite_in = (type_ff == dmc_pkg::REQ_WRITE);
                     pblock_in = block_ff;
                     pidx_in   = idx_ff;
                     poff_in   = off_ff;
                     pdata_in  = wdata_ff;
                     rc_in     = '0;
                     res_in.status_code = dmc_pkg::STAT_MISS;
                     res_in.bus_cmd     = dmc_pkg::CMD_FETCH;
                     res_in.bus_address = BA'(block_ff);
                     if (st_rd == dmc_pkg::LS_MODIFIED) begin
                        wtag_in    = tag_rd;
                        row_in     = idx_ff;
                        wst_in     = dmc_pkg::STAT_MISS;
                        wbsnoop_in = 1'b0;
                        cnt_in     = '0;
                        state_in   = S_WB_ISSUE;
                     end
                  end
               end
               dmc_pkg::REQ_REFILL: begin
                  if (!pend_ff) begin
                     state_in = S_IDLE;
                  end else begin
                     dwe    = 1'b1;
                     dwaddr = DAW'(DAW'(pidx_ff) * DAW'(LW) + DAW'(rc_ff[OFFW-1:0]));
                     dwdata = rword_ff;
                     if (rc_ff == CNTW'(LW - 1)) begin
                        // last word: install line
                        pend_in = 1'b0;
                        rc_in   = '0;
                        mwe     = 1'b1;
                        mwaddr  = pidx_ff;
                        mwdata  = {pwrite_ff ? dmc_pkg::LS_MODIFIED : dmc_pkg::LS_CLEAN,
                                   pblock_ff};
                        valid_in[pidx_ff] = 1'b1;
                        if (pwrite_ff) begin
                           res_in.status_code = dmc_pkg::STAT_DONE;
                           res_in.bus_cmd     = dmc_pkg::CMD_INV;
                           res_in.bus_address = BA'(pblock_ff);
                           state_in = S_FILLW;
                        end else begin
                           row_in   = pidx_ff;
                           roff_in  = poff_ff;
                           rdhit_in = 1'b0;
                           cnt_in   = '0;
                           state_in = S_RD_ISSUE;
                        end
                     end else begin
                        rc_in    = rc_ff + CNTW'(1);
                        state_in = S_IDLE;
                     end
                  end
               end
               dmc_pkg::REQ_SNOOP_INV: begin
                  if (smatch) begin
                     valid_in[sidx_ff] = 1'b0;
                  end
                  res_in.status_code = dmc_pkg::STAT_SNOOP;
                  res_in.hit         = shit;
               end
               dmc_pkg::REQ_SNOOP_QUERY: begin
                  res_in.status_code     = dmc_pkg::STAT_SNOOP;
                  res_in.hit             = shit;
                  res_in.modified_answer = shit && (st_rd == dmc_pkg::LS_MODIFIED);
               end
               dmc_pkg::REQ_SNOOP_WB: begin
                  res_in.status_code = dmc_pkg::STAT_SNOOP;
                  res_in.hit         = shit;
                  if (shit && st_rd == dmc_pkg::LS_MODIFIED) begin
                     mwe        = 1'b1;
                     mwdata     = {dmc_pkg::LS_CLEAN, tag_rd};
                     wtag_in    = tag_rd;
                     row_in     = sidx_ff;
                     wst_in     = dmc_pkg::STAT_SNOOP;
                     wbsnoop_in = 1'b1;
                     cnt_in     = '0;
                     state_in   = S_WB_ISSUE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_FILLW: begin
            // store the pending write word into the new line
            dwe      = 1'b1;
            dwaddr   = DAW'(DAW'(pidx_ff) * DAW'(LW) + DAW'(poff_ff));
            dwdata   = pdata_ff;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_in   = res_ff;
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_WB_ISSUE: begin
            state_in = S_WB_OUT;
         end
         S_WB_OUT: begin
            if (rsp_free) begin
               rsp_in             = '0;
               rsp_in.status_code = wst_ff;
               rsp_in.bus_cmd     = dmc_pkg::CMD_WRITE;
               rsp_in.bus_address = BA'(BA'(wtag_ff) * BA'(LW) + BA'(cnt_ff));
               rsp_in.bus_data    = drdata;
               rsp_in.last        = wbsnoop_ff && (cnt_ff == CNTW'(LW - 1));
               rsp_load           = 1'b1;
               if (cnt_ff == CNTW'(LW - 1)) begin
                  state_in = wbsnoop_ff ? S_IDLE : S_RESP;
               end else begin
                  cnt_in   = cnt_ff + CNTW'(1);
                  state_in = S_WB_ISSUE;
               end
            end
         end
         S_RD_ISSUE: begin
            state_in = S_RD_OUT;
         end
         S_RD_OUT: begin
            if (rsp_free) begin
               rsp_in             = '0;
               rsp_in.status_code = dmc_pkg::STAT_DONE;
               rsp_in.read_data   = drdata;
               rsp_in.hit         = rdhit_ff;
               rsp_in.last        = (cnt_ff == CNTW'(SCALE - 1));
               rsp_load           = 1'b1;
               if (cnt_ff == CNTW'(SCALE - 1)) begin
                  state_in = S_IDLE;
               end else begin
                  cnt_in   = cnt_ff + CNTW'(1);
                  state_in = S_RD_ISSUE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // response valid: set on load, drop when taken
      if (rsp_load) begin
         rspv_in = 1'b1;
      end else if (!rsp_stall) begin
         rspv_in = 1'b0;
      end else begin
         rspv_in = rspv_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         valid_ff  <= '0;
         pend_ff   <= 1'b0;
         pwrite_ff <= 1'b0;
         rc_ff     <= '0;
         rspv_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         pend_ff   <= pend_in;
         pwrite_ff <= pwrite_in;
         rc_ff     <= rc_in;
         rspv_ff   <= rspv_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      type_ff    <= type_in;
      addr_ff    <= addr_in;
      wdata_ff   <= wdata_in;
      rword_ff   <= rword_in;
      sblock_ff  <= sblock_in;
      busy_ff    <= busy_in;
      block_ff   <= block_in;
      sq_ff      <= sq_in;
      iq_ff      <= iq_in;
      off_ff     <= off_in;
      sidx_ff    <= sidx_in;
      idx_ff     <= idx_in;
      midx_ff    <= midx_in;
      pblock_ff  <= pblock_in;
      pidx_ff    <= pidx_in;
      poff_ff    <= poff_in;
      pdata_ff   <= pdata_in;
      cnt_ff     <= cnt_in;
      row_ff     <= row_in;
      roff_ff    <= roff_in;
      rdhit_ff   <= rdhit_in;
      wtag_ff    <= wtag_in;
      wst_ff     <= wst_in;
      wbsnoop_ff <= wbsnoop_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   // drive response ports
   assign rsp_valid           = rspv_ff;
   assign rsp_status_code     = rsp_ff.status_code;
   assign rsp_read_data       = rsp_ff.read_data;
   assign rsp_hit             = rsp_ff.hit;
   assign rsp_modified_answer = rsp_ff.modified_answer;
   assign rsp_bus_cmd         = rsp_ff.bus_cmd;
   assign rsp_bus_address     = rsp_ff.bus_address;
   assign rsp_bus_data        = rsp_ff.bus_data;
   assign rsp_last            = rsp_ff.last;

endmodule

FILE: rtl/dmc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module dmc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/dmc_checker.sv
// Port-level checks of the cache response channel, bound to the top level.
module dmc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [1:0]                    rsp_status_code,
   input logic [1:0]                    rsp_bus_cmd,
   input logic [dmc_pkg::BUSA_BITS-1:0] rsp_bus_address,
   input logic [31:0]                   rsp_bus_data,
   input logic                          rsp_last
);

   // hold a stalled response
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bus_data) &&
      $stable(rsp_bus_address) && $stable(rsp_last))
      else $error("stalled response changed");

   // writeback words belong to a miss or a snoop writeback
   a_wb_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bus_cmd == dmc_pkg::CMD_WRITE |->
      rsp_status_code == dmc_pkg::STAT_MISS || rsp_status_code == dmc_pkg::STAT_SNOOP)
      else $error("writeback word with wrong status");

   // a retry is always the only response
   a_retry_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status_code == dmc_pkg::STAT_RETRY |-> rsp_last)
      else $error("retry not final");

   // a block fetch closes a miss
   a_fetch_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bus_cmd == dmc_pkg::CMD_FETCH |->
      rsp_last && rsp_status_code == dmc_pkg::STAT_MISS)
      else $error("fetch not the final miss response");

endmodule

bind direct_mapped_msi_cache_unit dmc_checker u_dmc_checker (.*);
